// ----- src/ufm_pkg.sv -----
package ufm_pkg;

    // Payload widths, fixed by the item format
    localparam int CMD_W      = 1;
    localparam int CELL_W     = 5;
    localparam int DIR_W      = 1;
    localparam int WALL_W     = 7;
    localparam int GRID_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int GRID_RESET = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

    // Command and direction codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b0;
    localparam logic [CMD_W-1:0] CMD_EDGE  = 1'b1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 1'b0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 1'b1;

    // Microprogram step counter
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_IDLE      = 4'd0;
    localparam step_t ST_SETUP     = 4'd1;
    localparam step_t ST_FIND      = 4'd2;
    localparam step_t ST_HOP       = 4'd3;
    localparam step_t ST_COMP_RD   = 4'd4;
    localparam step_t ST_COMP      = 4'd5;
    localparam step_t ST_PASS      = 4'd6;
    localparam step_t ST_LOAD_B    = 4'd7;
    localparam step_t ST_MERGE     = 4'd8;
    localparam step_t ST_OUT       = 4'd9;
    localparam step_t ST_RET       = 4'd10;
    localparam step_t ST_SWEEP     = 4'd11;
    localparam step_t ST_SWEEP_END = 4'd12;
    localparam step_t ST_SWEEP_OUT = 4'd13;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_CLEAR_CMD,
        C_REJECT,
        C_RDATA_NE_ROOT,
        C_CUR_IS_ROOT,
        C_SECOND,
        C_OUT_BUSY,
        C_SWEEP_MORE,
        C_BOOT
    } cond_t;

    // Read address source
    typedef enum logic [1:0] {
        RD_ROOT,
        RD_CUR,
        RD_RDATA
    } rd_sel_t;

    // Datapath action
    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_SETUP,
        A_HOP,
        A_COMP,
        A_LOAD_B,
        A_MERGE,
        A_OUT,
        A_SWEEP,
        A_CLR_BOOT
    } action_t;

    typedef struct packed {
        cond_t   cond;
        step_t   target;
        rd_sel_t rd_sel;
        action_t action;
    } ucode_t;

    // Control store: jump to target when cond holds, else fall through
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{cond: C_ALWAYS, target: ST_IDLE, rd_sel: RD_ROOT, action: A_NONE};
        case (step)
            ST_IDLE:      w = '{C_NO_START,      ST_IDLE,   RD_ROOT,  A_ACCEPT};
            ST_SETUP:     w = '{C_CLEAR_CMD,     ST_SWEEP,  RD_ROOT,  A_SETUP};
            ST_FIND:      w = '{C_REJECT,        ST_OUT,    RD_ROOT,  A_NONE};
            ST_HOP:       w = '{C_RDATA_NE_ROOT, ST_HOP,    RD_RDATA, A_HOP};
            ST_COMP_RD:   w = '{C_CUR_IS_ROOT,   ST_PASS,   RD_CUR,   A_NONE};
            ST_COMP:      w = '{C_RDATA_NE_ROOT, ST_COMP,   RD_RDATA, A_COMP};
            ST_PASS:      w = '{C_SECOND,        ST_MERGE,  RD_ROOT,  A_NONE};
            ST_LOAD_B:    w = '{C_ALWAYS,        ST_FIND,   RD_ROOT,  A_LOAD_B};
            ST_MERGE:     w = '{C_NEVER,         ST_IDLE,   RD_ROOT,  A_MERGE};
            ST_OUT:       w = '{C_OUT_BUSY,      ST_OUT,    RD_ROOT,  A_OUT};
            ST_RET:       w = '{C_ALWAYS,        ST_IDLE,   RD_ROOT,  A_NONE};
            ST_SWEEP:     w = '{C_SWEEP_MORE,    ST_SWEEP,  RD_ROOT,  A_SWEEP};
            ST_SWEEP_END: w = '{C_BOOT,          ST_IDLE,   RD_ROOT,  A_CLR_BOOT};
            ST_SWEEP_OUT: w = '{C_ALWAYS,        ST_OUT,    RD_ROOT,  A_NONE};
            default:      w = '{C_ALWAYS,        ST_IDLE,   RD_ROOT,  A_NONE};
        endcase
        return w;
    endfunction

endpackage

// ----- src/ufm_req_if.sv -----
interface ufm_req_if
    import ufm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
    logic [DIR_W-1:0]  direction;

    modport source (output valid, output command, output cell_row, output cell_col,
                    output direction, input ready);
    modport sink   (input valid, input command, input cell_row, input cell_col,
                    input direction, output ready);
endinterface

// ----- src/ufm_rsp_if.sv -----
interface ufm_rsp_if
    import ufm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              wall_opened;
    logic [WALL_W-1:0] wall_row;
    logic [WALL_W-1:0] wall_col;
    logic              edge_rejected;

    modport source (output valid, output wall_opened, output wall_row, output wall_col,
                    output edge_rejected, input ready);
    modport sink   (input valid, input wall_opened, input wall_row, input wall_col,
                    input edge_rejected, output ready);
endinterface

// ----- src/union_find_maze_edge_merger_core.sv -----
// Edge item: the sequencer follows parent hops to the root of each of the two cells and
// re-points every node on each of the two root walks, then merges the roots and outputs.
// Edge off the grid: rejected without a walk. Clear item: the whole table is swept first.
// One item at a time, set by the single read port of the parent table; a stalled result
// holds the sequencer in its output step. Reset: rst_n is asynchronous, active low; the table
// is then swept (no transfers accepted) and grid sizes are 32.
module union_find_maze_edge_merger_core
    import ufm_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ufm_req_if.sink              req,
    ufm_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GRID_W-1:0]    cfg_data
);

    localparam int TABLE = MAX_ROWS * MAX_COLS;
    localparam int IDX_W = $clog2(TABLE);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE - 1);

    // control state
    step_t             pc_reg, pc_next;
    logic              boot_reg;
    logic              pass_reg;
    logic [IDX_W-1:0]  sweep_reg;
    logic              out_valid_reg;
    logic [GRID_W-1:0] grid_rows_reg;
    logic [GRID_W-1:0] grid_cols_reg;

    // datapath registers
    logic [CMD_W-1:0]  cmd_reg;
    logic [CELL_W-1:0] row_reg;
    logic [CELL_W-1:0] col_reg;
    logic [DIR_W-1:0]  dir_reg;
    logic [IDX_W-1:0]  b_reg;
    logic [IDX_W-1:0]  root_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  ra_reg;
    logic              res_opened_reg;
    logic              res_rej_reg;
    logic [WALL_W-1:0] res_row_reg;
    logic [WALL_W-1:0] res_col_reg;
    logic              out_opened_reg;
    logic              out_rej_reg;
    logic [WALL_W-1:0] out_row_reg;
    logic [WALL_W-1:0] out_col_reg;

    ucode_t            uc;
    logic              take;
    logic              req_xfer;
    logic              out_busy;
    logic [CELL_W:0]   row2;
    logic [CELL_W:0]   col2;
    logic              edge_ok;
    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  idx_b;
    logic              roots_differ;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [IDX_W-1:0]  mem_rdata;

    assign uc        = ucode_rom(pc_reg);
    assign req.ready = (pc_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign out_busy  = out_valid_reg && !rsp.ready;

    // second cell and grid check
    assign row2 = {1'b0, row_reg} + {{CELL_W{1'b0}}, dir_reg == DIR_DOWN};
    assign col2 = {1'b0, col_reg} + {{CELL_W{1'b0}}, dir_reg == DIR_RIGHT};
    assign edge_ok = ({1'b0, row_reg} < grid_rows_reg) && (int'(row_reg) < MAX_ROWS)
                  && ({1'b0, col_reg} < grid_cols_reg) && (int'(col_reg) < MAX_COLS)
                  && (row2 < grid_rows_reg) && (int'(row2) < MAX_ROWS)
                  && (col2 < grid_cols_reg) && (int'(col2) < MAX_COLS);
    assign idx_a = IDX_W'(int'(row_reg) * MAX_COLS + int'(col_reg));
    assign idx_b = IDX_W'(int'(row2) * MAX_COLS + int'(col2));
    assign roots_differ = (ra_reg != root_reg);

    // jump condition
    always_comb
    begin
        case (uc.cond)
            C_NEVER:         take = 1'b0;
            C_ALWAYS:        take = 1'b1;
            C_NO_START:      take = !req_xfer;
            C_CLEAR_CMD:     take = (cmd_reg == CMD_CLEAR);
            C_REJECT:        take = res_rej_reg;
            C_RDATA_NE_ROOT: take = (mem_rdata != root_reg);
            C_CUR_IS_ROOT:   take = (cur_reg == root_reg);
            C_SECOND:        take = pass_reg;
            C_OUT_BUSY:      take = out_busy;
            C_SWEEP_MORE:    take = (sweep_reg != IDX_LAST);
            C_BOOT:          take = boot_reg;
            default:         take = 1'b0;
        endcase
        pc_next = take ? uc.target : pc_reg + step_t'(1);
    end

    // table ports
    always_comb
    begin
        case (uc.rd_sel)
            RD_ROOT:  mem_raddr = root_reg;
            RD_CUR:   mem_raddr = cur_reg;
            RD_RDATA: mem_raddr = mem_rdata;
            default:  mem_raddr = root_reg;
        endcase
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = root_reg;
        case (uc.action)
            A_COMP:
            begin
                mem_we = 1'b1;
            end
            A_MERGE:
            begin
                mem_we    = roots_differ;
                mem_waddr = ra_reg;
            end
            A_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = sweep_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    ufm_parent_ram #(
        .DEPTH  (TABLE),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_SWEEP;
            boot_reg      <= 1'b1;
            pass_reg      <= 1'b0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            grid_rows_reg <= GRID_W'(GRID_RESET);
            grid_cols_reg <= GRID_W'(GRID_RESET);
        end
        else
        begin
            pc_reg <= pc_next;
            if (uc.action == A_SETUP)
            begin
                pass_reg <= 1'b0;
            end
            if (uc.action == A_LOAD_B)
            begin
                pass_reg <= 1'b1;
            end
            if (uc.action == A_SWEEP)
            begin
                sweep_reg <= (sweep_reg == IDX_LAST) ? '0 : sweep_reg + IDX_W'(1);
            end
            if (uc.action == A_CLR_BOOT)
            begin
                boot_reg <= 1'b0;
            end
            // output register
            if (uc.action == A_OUT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                    REG_GRID_COLS: grid_cols_reg <= cfg_data;
                    default:       grid_rows_reg <= grid_rows_reg;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (uc.action)
            A_ACCEPT:
            begin
                if (req_xfer)
                begin
                    cmd_reg <= req.command;
                    row_reg <= req.cell_row;
                    col_reg <= req.cell_col;
                    dir_reg <= req.direction;
                end
            end
            A_SETUP:
            begin
                root_reg       <= idx_a;
                cur_reg        <= idx_a;
                b_reg          <= idx_b;
                res_opened_reg <= 1'b0;
                res_rej_reg    <= (cmd_reg == CMD_EDGE) && !edge_ok;
                res_row_reg    <= '0;
                res_col_reg    <= '0;
            end
            A_HOP:
            begin
                root_reg <= mem_rdata;
            end
            A_COMP:
            begin
                cur_reg <= mem_rdata;
            end
            A_LOAD_B:
            begin
                ra_reg   <= root_reg;
                root_reg <= b_reg;
                cur_reg  <= b_reg;
            end
            A_MERGE:
            begin
                res_opened_reg <= roots_differ;
                if (roots_differ)
                begin
                    res_row_reg <= {1'b0, row_reg, 1'b0} + WALL_W'(1)
                                 + WALL_W'(dir_reg == DIR_DOWN);
                    res_col_reg <= {1'b0, col_reg, 1'b0} + WALL_W'(1)
                                 + WALL_W'(dir_reg == DIR_RIGHT);
                end
            end
            A_OUT:
            begin
                if (!out_busy)
                begin
                    out_opened_reg <= res_opened_reg;
                    out_rej_reg    <= res_rej_reg;
                    out_row_reg    <= res_row_reg;
                    out_col_reg    <= res_col_reg;
                end
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.wall_opened   = out_opened_reg;
    assign rsp.edge_rejected = out_rej_reg;
    assign rsp.wall_row      = out_row_reg;
    assign rsp.wall_col      = out_col_reg;

endmodule

// ----- src/ufm_parent_ram.sv -----
// Parent table: one write port, one read port, registered read data
module ufm_parent_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ADDR_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ufm_checker.sv -----
// Port-level checks on the edge merger
module ufm_checker
    import ufm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              wall_opened,
    input logic [WALL_W-1:0] wall_row,
    input logic [WALL_W-1:0] wall_col,
    input logic              edge_rejected
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(wall_opened)
            && $stable(wall_row) && $stable(wall_col) && $stable(edge_rejected))
        else $error("stalled result changed");

    // one item at a time: busy right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input ready straight after a transfer");

    a_open_not_rej: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && wall_opened |-> !edge_rejected)
        else $error("opened wall on a rejected edge");

    // an opened wall lies between two cells: one coordinate odd, one even
    a_wall_parity: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && wall_opened |-> wall_row[0] != wall_col[0])
        else $error("opened wall at a cell or corner position");

    a_closed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !wall_opened |-> wall_row == '0 && wall_col == '0)
        else $error("wall coordinates set without an opened wall");

endmodule

bind union_find_maze_edge_merger_core ufm_checker u_ufm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .wall_opened   (rsp.wall_opened),
    .wall_row      (rsp.wall_row),
    .wall_col      (rsp.wall_col),
    .edge_rejected (rsp.edge_rejected)
);
